// ----- src/sdr_pkg.sv -----
`timescale 1ns / 1ps

package sdr_pkg;

    // Number of entries in the warm-range exponential table.
    localparam int EXP_TABLE_ENTRIES = 64;
    localparam int EXP_IDX_W         = $clog2(EXP_TABLE_ENTRIES);
    // (T - 20 C) * entries, with T - 20 C below 2^13.
    localparam int EXP_P_W           = 13 + $clog2(EXP_TABLE_ENTRIES);
    // Value divided by 1024 before the divide by five.
    localparam int EXP_V_W           = EXP_P_W - 10;
    // Reciprocal of five, ceil(2^17 / 5); exact for values below 43690.
    localparam logic [14:0] RECIP_5  = 15'd26215;
    localparam int RECIP_SHIFT       = 17;
    localparam int EXP_R_W           = EXP_V_W + 15;
    localparam int EXP_Q_W           = EXP_R_W - RECIP_SHIFT;

    // Temperature factor fits in 20 bits (exp stays below 16 in the table range).
    localparam int FT_W  = 20;
    // Water factor reaches 8 * 2^32.
    localparam int FW_W  = 35;
    // One quotient bit per divider stage.
    localparam int DIV_STEPS = 32;

    // Saturation ratio knees and water factor at the upper knee, Q16.16.
    localparam logic [31:0] X_LOW   = 32'd52429;
    localparam logic [31:0] X_HIGH  = 32'd58982;
    localparam logic [31:0] FW_KNEE = 32'd13107;

    // Temperature breakpoints, Q8.8.
    localparam logic signed [14:0] T_2C  = 15'sd512;
    localparam logic signed [14:0] T_6C  = 15'sd1536;
    localparam logic signed [14:0] T_20C = 15'sd5120;
    localparam logic signed [14:0] T_40C = 15'sd10240;

    // Slopes of the linear temperature branches, Q0.16.
    localparam logic [13:0] C_015 = 14'd9830;
    localparam logic [13:0] C_010 = 14'd6554;

    // Register map and reset values.
    typedef enum logic {
        REG_ALPHA_GAIN,
        REG_K_OVER_DT
    } reg_idx_t;

    localparam logic [15:0] ALPHA_RESET = 16'd6554;
    localparam logic [23:0] KDT_RESET   = 24'd1365;

    typedef struct packed {
        logic [15:0] alpha_gain;
        logic [23:0] k_over_dt;
    } cfg_t;

    // Per-layer values that ride alongside the divider.
    typedef struct packed {
        logic [FT_W-1:0] ft;
        logic [31:0]     cap;
        logic [31:0]     co2;
        logic            hot;
        logic            ws_zero;
    } side_t;

    typedef struct packed {
        logic [31:0] amount;
        logic        hot;
    } res_t;

    typedef logic [31:0] exp_table_t [EXP_TABLE_ENTRIES];

    // Shift-and-subtract quotient, used only while building the table.
    function automatic longint unsigned const_div(longint unsigned num_in,
                                                  longint unsigned den_in);
        longint unsigned quo;
        longint unsigned rem;
        quo = 0;
        rem = 0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num_in[b]};
            if (rem >= den_in)
            begin
                rem    = rem - den_in;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Builds exp(q) at the midpoint of each table interval, Q16.16 rounded.
    // The quadratic is evaluated exactly and exp is a Taylor sum in Q8.24.
    function automatic exp_table_t build_exp_table();
        exp_table_t      tbl;
        longint unsigned n;
        longint unsigned a;
        longint unsigned num;
        longint unsigned q;
        longint unsigned term;
        longint unsigned sum;
        logic            done;
        n = longint'(EXP_TABLE_ENTRIES);
        for (int i = 0; i < EXP_TABLE_ENTRIES; i++)
        begin
            a    = 2 * n + 2 * longint'(i) + 1;
            num  = 470 * n * n + 193 * a * a - 270 * a * n;
            q    = const_div(num << 24, 1000 * n * n);
            term = 64'd1 << 24;
            sum  = term;
            done = 1'b0;
            for (int k = 1; k <= 40; k++)
            begin
                if (!done)
                begin
                    term = const_div((term * q) >> 24, 64'(k));
                    if (term == 0)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        sum = sum + term;
                    end
                end
            end
            tbl[i] = 32'((sum + 128) >> 8);
        end
        return tbl;
    endfunction

    localparam exp_table_t EXP_TABLE = build_exp_table();

endpackage

// ----- src/sdr_cfg.sv -----
`timescale 1ns / 1ps

module sdr_cfg
    import sdr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic        wr_en;
    reg_idx_t    reg_idx;
    logic [15:0] alpha_reg;
    logic [15:0] alpha_next;
    logic [23:0] kdt_reg;
    logic [23:0] kdt_next;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = reg_idx_t'(paddr[2]);

    // Register write decode.
    always_comb
    begin
        alpha_next = alpha_reg;
        kdt_next   = kdt_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_ALPHA_GAIN: alpha_next = pwdata[15:0];
                REG_K_OVER_DT:  kdt_next   = pwdata[23:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= ALPHA_RESET;
            kdt_reg   <= KDT_RESET;
        end
        else
        begin
            alpha_reg <= alpha_next;
            kdt_reg   <= kdt_next;
        end
    end

    // Read-back mux.
    always_comb
    begin
        unique case (reg_idx)
            REG_ALPHA_GAIN: prdata = {16'd0, alpha_reg};
            REG_K_OVER_DT:  prdata = {8'd0, kdt_reg};
        endcase
    end

    assign cfg.alpha_gain = alpha_reg;
    assign cfg.k_over_dt  = kdt_reg;

endmodule

// ----- src/sdr_front.sv -----
`timescale 1ns / 1ps

module sdr_front
    import sdr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  logic [31:0]        co2_rate,
    input  logic [15:0]        water_content,
    input  logic [15:0]        water_saturated,
    input  logic signed [14:0] temperature,
    input  logic [31:0]        nitrate_left,
    input  logic [23:0]        k_over_dt,
    output logic               out_valid,
    output logic [15:0]        out_wc,
    output logic [15:0]        out_ws,
    output side_t              out_side
);

    typedef enum logic [1:0] {
        FT_ZERO,
        FT_LIN,
        FT_WARM
    } ft_sel_t;

    // Stage one: branch choice and the raw products.
    ft_sel_t                  s1_sel_next;
    logic [13:0]              s1_coef;
    logic [12:0]              s1_opnd;
    logic signed [14:0]       t_minus_2c;
    logic signed [14:0]       t_minus_20c;
    logic [12:0]              warm_d;
    logic [26:0]              s1_lin_next;
    logic [EXP_P_W-1:0]       s1_expp_next;
    logic [55:0]              s1_cap_next;

    logic                     s1_valid_reg;
    ft_sel_t                  s1_sel_reg;
    logic [26:0]              s1_lin_reg;
    logic [EXP_P_W-1:0]       s1_expp_reg;
    logic [55:0]              s1_cap_reg;
    logic                     s1_hot_reg;
    logic [31:0]              s1_co2_reg;
    logic [15:0]              s1_wc_reg;
    logic [15:0]              s1_ws_reg;

    // Stage two: divide by five via reciprocal, cap saturation.
    logic [EXP_V_W-1:0]       s2_v;
    logic [EXP_R_W-1:0]       s2_recip_next;
    logic [31:0]              s2_cap_next;

    logic                     s2_valid_reg;
    ft_sel_t                  s2_sel_reg;
    logic [18:0]              s2_ftlin_reg;
    logic [EXP_R_W-1:0]       s2_recip_reg;
    logic [31:0]              s2_cap_reg;
    logic                     s2_hot_reg;
    logic [31:0]              s2_co2_reg;
    logic [15:0]              s2_wc_reg;
    logic [15:0]              s2_ws_reg;

    // Stage three: table read and factor select.
    logic [EXP_Q_W-1:0]       s3_q;
    logic [EXP_IDX_W-1:0]     s3_idx;
    logic [FT_W-1:0]          s3_ft_next;

    logic                     s3_valid_reg;
    side_t                    s3_side_reg;
    logic [15:0]              s3_wc_reg;
    logic [15:0]              s3_ws_reg;

    assign t_minus_2c  = temperature - T_2C;
    assign t_minus_20c = temperature - T_20C;
    assign warm_d      = t_minus_20c[12:0];

    // Pick the temperature branch and feed the shared linear multiplier.
    always_comb
    begin
        if (temperature < T_2C)
        begin
            s1_sel_next = FT_ZERO;
        end
        else if (temperature < T_20C)
        begin
            s1_sel_next = FT_LIN;
        end
        else
        begin
            s1_sel_next = FT_WARM;
        end

        if (temperature < T_6C)
        begin
            s1_coef = C_015;
            s1_opnd = t_minus_2c[12:0];
        end
        else
        begin
            s1_coef = C_010;
            s1_opnd = temperature[12:0];
        end

        s1_lin_next  = {13'd0, s1_coef} * {14'd0, s1_opnd};
        s1_expp_next = EXP_P_W'(warm_d) * EXP_P_W'(EXP_TABLE_ENTRIES);
        s1_cap_next  = {32'd0, k_over_dt} * {24'd0, nitrate_left};
    end

    // Stage two logic.
    always_comb
    begin
        s2_v          = s1_expp_reg[EXP_P_W-1:10];
        s2_recip_next = EXP_R_W'(s2_v) * EXP_R_W'(RECIP_5);
        if (|s1_cap_reg[55:48])
        begin
            s2_cap_next = '1;
        end
        else
        begin
            s2_cap_next = s1_cap_reg[47:16];
        end
    end

    // Stage three logic: table index is clamped to the last entry.
    always_comb
    begin
        s3_q = s2_recip_reg[EXP_R_W-1:RECIP_SHIFT];
        if (s3_q >= EXP_Q_W'(EXP_TABLE_ENTRIES))
        begin
            s3_idx = EXP_IDX_W'(EXP_TABLE_ENTRIES - 1);
        end
        else
        begin
            s3_idx = s3_q[EXP_IDX_W-1:0];
        end

        case (s2_sel_reg)
            FT_LIN:  s3_ft_next = {1'b0, s2_ftlin_reg};
            FT_WARM: s3_ft_next = EXP_TABLE[s3_idx][FT_W-1:0];
            default: s3_ft_next = '0;
        endcase
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_sel_reg   <= s1_sel_next;
            s1_lin_reg   <= s1_lin_next;
            s1_expp_reg  <= s1_expp_next;
            s1_cap_reg   <= s1_cap_next;
            s1_hot_reg   <= (temperature >= T_40C);
            s1_co2_reg   <= co2_rate;
            s1_wc_reg    <= water_content;
            s1_ws_reg    <= water_saturated;

            s2_sel_reg   <= s1_sel_reg;
            s2_ftlin_reg <= s1_lin_reg[26:8];
            s2_recip_reg <= s2_recip_next;
            s2_cap_reg   <= s2_cap_next;
            s2_hot_reg   <= s1_hot_reg;
            s2_co2_reg   <= s1_co2_reg;
            s2_wc_reg    <= s1_wc_reg;
            s2_ws_reg    <= s1_ws_reg;

            s3_side_reg.ft      <= s3_ft_next;
            s3_side_reg.cap     <= s2_cap_reg;
            s3_side_reg.co2     <= s2_co2_reg;
            s3_side_reg.hot     <= s2_hot_reg;
            s3_side_reg.ws_zero <= (s2_ws_reg == 16'd0);
            s3_wc_reg           <= s2_wc_reg;
            s3_ws_reg           <= s2_ws_reg;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_wc    = s3_wc_reg;
    assign out_ws    = s3_ws_reg;
    assign out_side  = s3_side_reg;

endmodule

// ----- src/sdr_divider.sv -----
`timescale 1ns / 1ps

module sdr_divider
    import sdr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        in_valid,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    input  side_t       in_side,
    output logic        out_valid,
    output logic [31:0] quotient,
    output side_t       out_side
);

    // Stage inputs, selected from the ports or the previous stage.
    logic        stg_valid [DIV_STEPS];
    logic [15:0] stg_rem   [DIV_STEPS];
    logic [31:0] stg_work  [DIV_STEPS];
    logic [15:0] stg_dvs   [DIV_STEPS];
    side_t       stg_side  [DIV_STEPS];

    logic [16:0] trial     [DIV_STEPS];
    logic        take      [DIV_STEPS];
    logic [15:0] rem_next  [DIV_STEPS];
    logic [31:0] work_next [DIV_STEPS];

    logic        valid_reg [DIV_STEPS];
    logic [15:0] rem_reg   [DIV_STEPS];
    logic [31:0] work_reg  [DIV_STEPS];
    logic [15:0] dvs_reg   [DIV_STEPS];
    side_t       side_reg  [DIV_STEPS];

    always_comb
    begin
        stg_valid[0] = in_valid;
        stg_rem[0]   = '0;
        stg_work[0]  = dividend;
        stg_dvs[0]   = divisor;
        stg_side[0]  = in_side;
        for (int s = 1; s < DIV_STEPS; s++)
        begin
            stg_valid[s] = valid_reg[s-1];
            stg_rem[s]   = rem_reg[s-1];
            stg_work[s]  = work_reg[s-1];
            stg_dvs[s]   = dvs_reg[s-1];
            stg_side[s]  = side_reg[s-1];
        end
    end

    // One restoring step per stage: the dividend shifts out of the work word
    // at the top while quotient bits shift in at the bottom.
    always_comb
    begin
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            trial[s] = {stg_rem[s], stg_work[s][31]};
            take[s]  = (trial[s] >= {1'b0, stg_dvs[s]});
            if (take[s])
            begin
                rem_next[s] = 16'(trial[s] - {1'b0, stg_dvs[s]});
            end
            else
            begin
                rem_next[s] = trial[s][15:0];
            end
            work_next[s] = {stg_work[s][30:0], take[s]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < DIV_STEPS; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            for (int s = 0; s < DIV_STEPS; s++)
            begin
                valid_reg[s] <= stg_valid[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s < DIV_STEPS; s++)
            begin
                rem_reg[s]  <= rem_next[s];
                work_reg[s] <= work_next[s];
                dvs_reg[s]  <= stg_dvs[s];
                side_reg[s] <= stg_side[s];
            end
        end
    end

    assign out_valid = valid_reg[DIV_STEPS-1];
    assign quotient  = work_reg[DIV_STEPS-1];
    assign out_side  = side_reg[DIV_STEPS-1];

endmodule

// ----- src/sdr_back.sv -----
`timescale 1ns / 1ps

module sdr_back
    import sdr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        in_valid,
    input  logic [31:0] quotient,
    input  side_t       in_side,
    input  logic [15:0] alpha_gain,
    output logic        out_valid,
    output res_t        out_res
);

    logic [FW_W-1:0] fw_next;
    logic [54:0]     prod1_next;
    logic [31:0]     g1;
    logic [47:0]     prod2_next;
    logic [31:0]     g2;
    logic [63:0]     prod3_next;
    logic [31:0]     rate;
    logic [31:0]     amount_next;

    logic            v1_reg;
    logic            v2_reg;
    logic            v3_reg;
    logic            v4_reg;
    logic            v5_reg;
    side_t           side1_reg;
    side_t           side2_reg;
    side_t           side3_reg;
    side_t           side4_reg;
    logic [FW_W-1:0] fw_reg;
    logic [54:0]     prod1_reg;
    logic [47:0]     prod2_reg;
    logic [63:0]     prod3_reg;
    res_t            res_reg;

    // Water factor from the saturation ratio.
    always_comb
    begin
        if (in_side.ws_zero || (quotient < X_LOW))
        begin
            fw_next = '0;
        end
        else if (quotient < X_HIGH)
        begin
            fw_next = FW_W'(quotient - X_LOW) << 1;
        end
        else
        begin
            fw_next = FW_W'(FW_KNEE) + {quotient - X_HIGH, 3'b000};
        end
    end

    // Product chain, one multiplier per stage.
    always_comb
    begin
        prod1_next = {20'd0, fw_reg} * {35'd0, side1_reg.ft};

        if (|prod1_reg[54:48])
        begin
            g1 = '1;
        end
        else
        begin
            g1 = prod1_reg[47:16];
        end
        prod2_next = {16'd0, g1} * {32'd0, alpha_gain};

        g2         = prod2_reg[47:16];
        prod3_next = {32'd0, g2} * {32'd0, side3_reg.co2};

        if (|prod3_reg[63:48])
        begin
            rate = '1;
        end
        else
        begin
            rate = prod3_reg[47:16];
        end
    end

    // Smaller of rate and cap; a hot layer gives nothing.
    always_comb
    begin
        if (side4_reg.hot)
        begin
            amount_next = '0;
        end
        else if (rate < side4_reg.cap)
        begin
            amount_next = rate;
        end
        else
        begin
            amount_next = side4_reg.cap;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fw_reg         <= fw_next;
            side1_reg      <= in_side;
            prod1_reg      <= prod1_next;
            side2_reg      <= side1_reg;
            prod2_reg      <= prod2_next;
            side3_reg      <= side2_reg;
            prod3_reg      <= prod3_next;
            side4_reg      <= side3_reg;
            res_reg.amount <= amount_next;
            res_reg.hot    <= side4_reg.hot;
        end
    end

    assign out_valid = v5_reg;
    assign out_res   = res_reg;

endmodule

// ----- src/sdr_out_buf.sv -----
`timescale 1ns / 1ps

module sdr_out_buf
    import sdr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  res_t in_res,
    output logic adv,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_res
);

    logic out_valid_reg;
    logic out_valid_next;
    logic skid_valid_reg;
    logic skid_valid_next;
    res_t out_reg;
    res_t skid_reg;
    logic take;
    logic pop;

    // The pipeline moves whenever the skid slot is free, so every word
    // leaving the last stage has a place to land.
    assign adv  = !skid_valid_reg;
    assign take = adv && in_valid;
    assign pop  = out_valid_reg && out_ready;

    always_comb
    begin
        if (skid_valid_reg)
        begin
            out_valid_next  = 1'b1;
            skid_valid_next = !pop;
        end
        else
        begin
            out_valid_next  = take || (out_valid_reg && !pop);
            skid_valid_next = take && out_valid_reg && !pop;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg && pop)
        begin
            out_reg <= skid_reg;
        end
        else if (take && (!out_valid_reg || pop))
        begin
            out_reg <= in_res;
        end

        if (take && out_valid_reg && !pop)
        begin
            skid_reg <= in_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held with no output word");

    a_overflow_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !skid_valid_reg && out_valid_reg && !out_ready) |=> skid_valid_reg)
        else $error("stalled word not caught by skid slot");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_ready) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid word not moved to output");
`endif

endmodule

// ----- src/soil_denitrification_rate_core.sv -----
`timescale 1ns / 1ps
// An accepted input word passes 3 front stages, 32 one-bit divider stages,
// 5 product stages and 1 output register before its result shows on m_tvalid.
// Throughput: one layer per cycle when the skid slot is free; the divider sets the depth.
// A two-entry output register and skid slot keep s_tready up while one result waits.
// Reset (rst_n low, asynchronous) empties the pipeline and restores both registers.

module soil_denitrification_rate_core
    import sdr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // co2_rate[31:0], water_content[47:32], water_saturated[63:48],
    // temperature[78:64], nitrate_left[110:79], zero pad[111]
    input  logic [111:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // converted_amount[31:0]
    output logic [31:0]  m_tdata,
    // temp_out_of_range[0]
    output logic [0:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    cfg_t               cfg;
    logic               adv;
    logic signed [14:0] temperature;

    logic               fr_valid;
    logic [15:0]        fr_wc;
    logic [15:0]        fr_ws;
    side_t              fr_side;

    logic               dv_valid;
    logic [31:0]        dv_quotient;
    side_t              dv_side;

    logic               bk_valid;
    res_t               bk_res;
    res_t               ob_res;

    assign temperature = signed'(s_tdata[78:64]);
    assign s_tready    = adv;

    sdr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sdr_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .adv             (adv),
        .in_valid        (s_tvalid),
        .co2_rate        (s_tdata[31:0]),
        .water_content   (s_tdata[47:32]),
        .water_saturated (s_tdata[63:48]),
        .temperature     (temperature),
        .nitrate_left    (s_tdata[110:79]),
        .k_over_dt       (cfg.k_over_dt),
        .out_valid       (fr_valid),
        .out_wc          (fr_wc),
        .out_ws          (fr_ws),
        .out_side        (fr_side)
    );

    // Saturation ratio in Q16.16: water content shifted up by 16 over saturation.
    sdr_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (fr_valid),
        .dividend  ({fr_wc, 16'd0}),
        .divisor   (fr_ws),
        .in_side   (fr_side),
        .out_valid (dv_valid),
        .quotient  (dv_quotient),
        .out_side  (dv_side)
    );

    sdr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (dv_valid),
        .quotient   (dv_quotient),
        .in_side    (dv_side),
        .alpha_gain (cfg.alpha_gain),
        .out_valid  (bk_valid),
        .out_res    (bk_res)
    );

    sdr_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (bk_valid),
        .in_res    (bk_res),
        .adv       (adv),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (ob_res)
    );

    assign m_tdata    = ob_res.amount;
    assign m_tuser[0] = ob_res.hot;

endmodule
